// ===== sv/pbpm_pkg.sv =====
// Package with the types, constants and codes of the packet buffer pool manager.
`default_nettype none

package pbpm_pkg;

    // Pool geometry.
    localparam int NUM_BUFFERS = 8;
    localparam int NUM_IFACES  = 4;

    // Widths of the internal buffer address and of the free counter.
    localparam int ADDR_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CNT_W  = $clog2(NUM_BUFFERS + 1);

    // Fixed field widths of the request and response channels.
    localparam int CMD_W   = 2;
    localparam int IFACE_W = 2;
    localparam int INDEX_W = 4;
    localparam int STAT_W  = 2;
    localparam int OWNER_W = 3;
    localparam int COUNT_W = 4;

    // Owner code that marks a buffer without an owner.
    localparam logic [OWNER_W-1:0] OWNER_NONE = OWNER_W'(NUM_IFACES);

    // Request commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_MARK  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    // Per-buffer state.
    typedef enum logic [1:0] {
        BS_FREE    = 2'd0,
        BS_LOADING = 2'd1,
        BS_LOADED  = 2'd2
    } t_bstate;

    // Response status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_NOFREE = 2'd1,
        STAT_RANGE  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // One entry of the buffer table.
    typedef struct packed {
        t_bstate             st;
        logic [OWNER_W-1:0]  owner;
    } t_entry;

    // Entry value after reset.
    localparam t_entry ENTRY_RESET = '{st: BS_FREE, owner: OWNER_NONE};

    // Write port of the buffer table.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_tbl_wr;

    // Update of the free map.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] idx;
        logic              set_free;
    } t_fm_upd;

endpackage

`default_nettype wire

// ===== sv/packet_buffer_pool_manager.sv =====
// Top level of the packet buffer pool manager: controller, response register and checks.
//
// Usage: requests enter on i_in_valid / o_in_ready carrying i_cmd, i_iface and
// i_buf_index. Each request gives exactly one response on o_out_valid /
// i_out_ready with o_status, o_result_index, o_buf_state, o_buf_owner and
// o_free_count. A request is accepted in the idle state, which also starts the
// read of the buffer table (synchronous memory); the execute state then modifies
// the entry, writes it back and loads the response register, from which the
// response is shown. No new request is taken until the read-then-write pass
// through the table ends and the controller is back in idle. A new request is
// accepted while a finished response still waits in the output register.
// If the receiver stalls and the output register is full, the request in
// work holds in the execute state until the register drains.
// Synchronous active-low reset marks every buffer free with no owner and
// empties the response register; no clearing pass is needed.
`default_nettype none

module packet_buffer_pool_manager
    import pbpm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [IFACE_W-1:0] i_iface,
    input  wire logic [INDEX_W-1:0] i_buf_index,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      logic [STAT_W-1:0]  o_status,
    output      logic [INDEX_W-1:0] o_result_index,
    output      logic [1:0]         o_buf_state,
    output      logic [OWNER_W-1:0] o_buf_owner,
    output      logic [COUNT_W-1:0] o_free_count
);

    t_state r_state;
    t_state n_state;

    // Captured request.
    t_cmd               r_cmd;
    logic [IFACE_W-1:0] r_iface;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_range_err;
    logic               r_nofree;

    // Response register.
    logic               r_out_valid;
    logic               n_out_valid;
    t_status            r_status;
    logic [INDEX_W-1:0] r_result_index;
    t_bstate            r_buf_state;
    logic [OWNER_W-1:0] r_buf_owner;
    logic [COUNT_W-1:0] r_free_count;

    logic               w_accept;
    logic               w_exec_go;
    logic               w_range_err;
    t_entry             w_rd_data;
    t_tbl_wr            w_wr;
    t_fm_upd            w_upd;
    logic               w_any_free;
    logic [ADDR_W-1:0]  w_first_free;
    logic [COUNT_W-1:0] w_count_next;
    logic [ADDR_W-1:0]  w_rd_addr;
    t_status            w_status;
    logic [INDEX_W-1:0] w_result_index;
    t_bstate            w_buf_state;
    logic [OWNER_W-1:0] w_buf_owner;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_range_err = ({2'b00, i_buf_index} >= (INDEX_W + 2)'(NUM_BUFFERS));
    assign w_rd_addr   = (t_cmd'(i_cmd) == CMD_ALLOC) ? w_first_free
                                                      : ADDR_W'(i_buf_index);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        o_in_ready = 1'b0;
        w_exec_go  = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_EXEC:  w_exec_go  = !r_out_valid || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request at acceptance.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= t_cmd'(i_cmd);
            r_iface     <= i_iface;
            r_addr      <= w_rd_addr;
            r_range_err <= w_range_err;
            r_nofree    <= !w_any_free;
        end
    end

    pbpm_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .i_wr      (w_wr),
        .o_rd_data (w_rd_data)
    );

    pbpm_free_map u_free_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_upd        (w_upd),
        .o_any_free   (w_any_free),
        .o_first_free (w_first_free),
        .o_count_next (w_count_next)
    );

    // Modify the read entry, build the write-back and the response.
    always_comb begin
        w_wr           = '{en: 1'b0, addr: r_addr, data: ENTRY_RESET};
        w_upd          = '{en: 1'b0, idx: r_addr, set_free: 1'b0};
        w_status       = STAT_OK;
        w_result_index = INDEX_W'(r_addr);
        w_buf_state    = BS_FREE;
        w_buf_owner    = OWNER_NONE;
        if (r_cmd == CMD_ALLOC) begin
            if (r_nofree) begin
                w_status       = STAT_NOFREE;
                w_result_index = INDEX_W'(NUM_BUFFERS);
            end else begin
                w_wr.en        = w_exec_go;
                w_wr.data      = '{st: BS_LOADING, owner: OWNER_W'(r_iface)};
                w_upd.en       = w_exec_go;
                w_buf_state    = BS_LOADING;
                w_buf_owner    = OWNER_W'(r_iface);
            end
        end else if (r_range_err) begin
            w_status       = STAT_RANGE;
            w_result_index = '0;
        end else begin
            unique case (r_cmd)
                CMD_FREE: begin
                    w_wr.en        = w_exec_go;
                    w_upd.en       = w_exec_go;
                    w_upd.set_free = 1'b1;
                end
                CMD_MARK: begin
                    w_wr.en     = w_exec_go;
                    w_wr.data   = '{st: BS_LOADED, owner: w_rd_data.owner};
                    w_upd.en    = w_exec_go;
                    w_buf_state = BS_LOADED;
                    w_buf_owner = w_rd_data.owner;
                end
                default: begin
                    w_buf_state = w_rd_data.st;
                    w_buf_owner = w_rd_data.owner;
                end
            endcase
        end
    end

    // Response valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_exec_go) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Response payload.
    always_ff @(posedge i_clk) begin
        if (w_exec_go) begin
            r_status       <= w_status;
            r_result_index <= w_result_index;
            r_buf_state    <= w_buf_state;
            r_buf_owner    <= w_buf_owner;
            r_free_count   <= w_count_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_result_index = r_result_index;
    assign o_buf_state    = r_buf_state;
    assign o_buf_owner    = r_buf_owner;
    assign o_free_count   = r_free_count;

`ifndef SYNTH
    // An accepted request always moves the controller into execution.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execution");

    // A failed allocation reports an empty pool.
    a_nofree_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_NOFREE) |-> (o_free_count == '0))
        else $error("no-free status with nonzero free count");

    // The free count never exceeds the pool size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_free_count} <= (COUNT_W + 1)'(NUM_BUFFERS)))
        else $error("free count above pool size");

    // A successful allocation reports a buffer that is loading.
    a_alloc_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec_go && r_cmd == CMD_ALLOC && !r_nofree)
            |=> (o_out_valid && o_buf_state == BS_LOADING))
        else $error("allocation response not in loading state");
`endif

endmodule

`default_nettype wire

// ===== sv/pbpm_table.sv =====
// Buffer table: synchronous memory of state and owner with per-entry valid bits.
`default_nettype none

module pbpm_table
    import pbpm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire t_tbl_wr           i_wr,
    output      t_entry            o_rd_data
);

    t_entry r_mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] r_vld;
    t_entry r_rd_data;
    logic   r_rd_vld;

    // Table write; the payload array needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Valid bits mark entries written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Registered read of data and valid bit.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    // An entry never written reads as its reset value.
    assign o_rd_data = r_rd_vld ? r_rd_data : ENTRY_RESET;

endmodule

`default_nettype wire

// ===== sv/pbpm_free_map.sv =====
// Free map: one flag per buffer, lowest-free search and free count.
`default_nettype none

module pbpm_free_map
    import pbpm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_fm_upd            i_upd,
    output      logic               o_any_free,
    output      logic [ADDR_W-1:0]  o_first_free,
    output      logic [COUNT_W-1:0] o_count_next
);

    logic [NUM_BUFFERS-1:0] r_free;
    logic [NUM_BUFFERS-1:0] n_free;
    logic [CNT_W-1:0]       w_cnt;

    // Next flag vector after the pending update.
    always_comb begin
        n_free = r_free;
        if (i_upd.en) begin
            n_free[i_upd.idx] = i_upd.set_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
        end else begin
            r_free <= n_free;
        end
    end

    // Priority encoder: lowest-numbered free buffer wins.
    always_comb begin
        o_first_free = '0;
        for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                o_first_free = ADDR_W'(i);
            end
        end
    end

    assign o_any_free = |r_free;

    // Population count of the updated vector.
    always_comb begin
        w_cnt = '0;
        for (int i = 0; i < NUM_BUFFERS; i++) begin
            w_cnt = w_cnt + CNT_W'(n_free[i]);
        end
    end

    assign o_count_next = COUNT_W'(w_cnt);

endmodule

`default_nettype wire
